// File: rtl/wfh_pkg.sv
// ----------------------------------------------------------------------------
// wfh_pkg
// Shared types and constants for the word frequency hash table.
// ----------------------------------------------------------------------------
package wfh_pkg;

    localparam int SLOTS        = 256;
    localparam int MAX_WORD_LEN = 16;
    localparam int BYTE_W       = 8;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int NSL_W        = $clog2(SLOTS + 1);
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
    localparam int IDX_W        = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int SUM_W        = $clog2(MAX_WORD_LEN * 255 + 1);
    localparam int SUMC_W       = $clog2(SUM_W + 1);
    localparam int CNT_W        = 16;
    localparam int SEP_RESET    = 32;
    localparam int PADDR_W      = 3;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NEW    = 3'd0,
        ST_RAISED = 3'd1,
        ST_FOUND  = 3'd2,
        ST_ABSENT = 3'd3,
        ST_LONG   = 3'd4,
        ST_FULL   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_MOD,
        TS_PROBE,
        TS_CMP
    } t_tstate;

    typedef struct packed {
        t_cmd              cmd;
        logic [BYTE_W-1:0] byte_in;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] slot;
    } t_out_word;

    typedef logic [MAX_WORD_LEN-1:0][BYTE_W-1:0] t_wbytes;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [LEN_W-1:0] len;
        t_wbytes          bytes;
    } t_row;

    typedef struct packed {
        logic              go;
        logic              clear;
        logic              is_add;
        logic [SUM_W-1:0]  sum;
        logic [NSL_W-1:0]  n;
        logic [LEN_W-1:0]  len;
    } t_job;

    typedef struct packed {
        logic      done;
        t_out_word res;
    } t_tbl_res;

endpackage

// File: rtl/wfh_mod.sv
// ----------------------------------------------------------------------------
// wfh_mod
// Bit-serial remainder of the byte sum by the active slot count.
// ----------------------------------------------------------------------------
module wfh_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wfh_pkg::SUM_W-1:0]  i_sum,
    input  logic [wfh_pkg::NSL_W-1:0]  i_n,
    output logic                       o_done,
    output logic [wfh_pkg::SLOT_W-1:0] o_rem
);
    import wfh_pkg::*;

    logic              r_run, n_run;
    logic              r_done, n_done;
    logic [SUMC_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SLOT_W-1:0] r_rem, n_rem;
    logic [NSL_W-1:0]  w_trial;

    always_comb begin
        w_trial = {1'b0, r_rem} << 1;
        w_trial[0] = r_sum[SUM_W-1];
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sum  = r_sum;
        n_rem  = r_rem;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_sum = i_sum;
            n_rem = '0;
        end else if (r_run) begin
            n_sum = r_sum << 1;
            if (w_trial >= i_n) begin
                n_rem = SLOT_W'(w_trial - i_n);
            end else begin
                n_rem = SLOT_W'(w_trial);
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == SUMC_W'(SUM_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_sum <= n_sum;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/wfh_table.sv
// ----------------------------------------------------------------------------
// wfh_table
// Slot memory, valid bits and linear probe sequencer.
// ----------------------------------------------------------------------------
module wfh_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wfh_pkg::t_job     i_job,
    input  wfh_pkg::t_wbytes  i_bytes,
    output logic              o_busy,
    output wfh_pkg::t_tbl_res o_res
);
    import wfh_pkg::*;

    t_tstate           r_state, n_state;
    logic [SLOT_W-1:0] r_s, n_s;
    logic [NSL_W-1:0]  r_probe, n_probe;
    logic              r_is_add, n_is_add;
    logic [SLOTS-1:0]  r_used;
    t_row              r_mem [SLOTS];
    t_row              r_rdata;
    logic              w_we;
    t_row              w_wrow;
    logic              w_set;
    logic              w_mod_done;
    logic [SLOT_W-1:0] w_rem;
    logic              w_match;
    logic [CNT_W-1:0]  w_inc;
    logic [NSL_W-1:0]  w_next;

    wfh_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_job.go),
        .i_sum   (i_job.sum),
        .i_n     (i_job.n),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    always_comb begin
        w_match = (r_rdata.len == i_job.len);
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            if ((LEN_W'(i) < i_job.len) && (r_rdata.bytes[i] != i_bytes[i])) begin
                w_match = 1'b0;
            end
        end
    end

    assign w_inc  = (r_rdata.count == '1) ? r_rdata.count : r_rdata.count + 1'b1;
    assign w_next = {1'b0, r_s} + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_s       = r_s;
        n_probe   = r_probe;
        n_is_add  = r_is_add;
        w_we      = 1'b0;
        w_set     = 1'b0;
        w_wrow    = r_rdata;
        o_res     = '0;
        unique case (r_state)
            TS_IDLE: begin
                if (i_job.go) begin
                    n_is_add = i_job.is_add;
                    n_state  = TS_MOD;
                end
            end
            TS_MOD: begin
                if (w_mod_done) begin
                    n_s     = w_rem;
                    n_probe = '0;
                    n_state = TS_PROBE;
                end
            end
            TS_PROBE: begin
                if (!r_used[r_s]) begin
                    o_res.done = 1'b1;
                    n_state    = TS_IDLE;
                    if (r_is_add) begin
                        w_we             = 1'b1;
                        w_set            = 1'b1;
                        w_wrow.count     = CNT_W'(1);
                        w_wrow.len       = i_job.len;
                        w_wrow.bytes     = i_bytes;
                        o_res.res.status = ST_NEW;
                        o_res.res.count  = CNT_W'(1);
                        o_res.res.slot   = r_s;
                    end else begin
                        o_res.res.status = ST_ABSENT;
                    end
                end else begin
                    n_state = TS_CMP;
                end
            end
            TS_CMP: begin
                if (w_match) begin
                    o_res.done     = 1'b1;
                    o_res.res.slot = r_s;
                    n_state        = TS_IDLE;
                    if (r_is_add) begin
                        w_we             = 1'b1;
                        w_wrow.count     = w_inc;
                        o_res.res.status = ST_RAISED;
                        o_res.res.count  = w_inc;
                    end else begin
                        o_res.res.status = ST_FOUND;
                        o_res.res.count  = r_rdata.count;
                    end
                end else if (r_probe == i_job.n - 1'b1) begin
                    o_res.done       = 1'b1;
                    o_res.res.status = r_is_add ? ST_FULL : ST_ABSENT;
                    n_state          = TS_IDLE;
                end else begin
                    n_s     = (w_next >= i_job.n) ? '0 : SLOT_W'(w_next);
                    n_probe = r_probe + 1'b1;
                    n_state = TS_PROBE;
                end
            end
            default: n_state = TS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            if (i_job.clear) begin
                r_used <= '0;
            end else if (w_set) begin
                r_used[r_s] <= 1'b1;
            end
        end
        r_s      <= n_s;
        r_probe  <= n_probe;
        r_is_add <= n_is_add;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_s] <= w_wrow;
        end
        r_rdata <= r_mem[r_s];
    end

    assign o_busy = (r_state != TS_IDLE);

endmodule

// File: rtl/word_frequency_hash_table.sv
// ----------------------------------------------------------------------------
// word_frequency_hash_table
// Splits a byte stream into words and counts or looks them up in a
// linear-probing hash table held in a synchronous slot memory.
//
// channel   ports                                  transfer
// input     start, busy, i_item                    start & !busy
// result    o_valid, o_result                      one-cycle strobe
// config    psel, penable, pwrite, paddr, pwdata   apb write, pready high
//
// a byte that is not a separator, a clear, or an overlong word end does
// not raise busy. any other word end holds busy through the bit-serial
// remainder and then TS_PROBE, plus TS_CMP for a used slot, for each
// probed slot (one slot memory read port).
// the result strobe follows in the cycle after the word leaves the table.
// reset clears valid bits at once; no clearing pass. results cannot stall.
// ----------------------------------------------------------------------------
module word_frequency_hash_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  wfh_pkg::t_in_word           i_item,
    output logic                        o_valid,
    output wfh_pkg::t_out_word          o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wfh_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import wfh_pkg::*;

    logic [BYTE_W-1:0] r_sep;
    logic [NSL_W-1:0]  r_slots;
    t_wbytes           r_wbytes;
    logic [LEN_W-1:0]  r_wlen;
    logic [SUM_W-1:0]  r_wsum;
    logic              r_long;
    logic              r_valid;
    t_out_word         r_res;
    logic              w_acc;
    logic              w_cfg_wr;
    logic              w_end;
    logic              w_drop;
    logic              w_long_res;
    logic              w_tbl_busy;
    logic [NSL_W-1:0]  w_n;
    t_job              w_job;
    t_tbl_res          w_tres;

    assign w_acc      = start && !busy;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_end      = w_acc && (i_item.cmd == CMD_ADD || i_item.cmd == CMD_QUERY)
                        && (i_item.byte_in == r_sep);
    assign w_long_res = w_end && r_long;
    assign w_drop     = w_long_res || w_tres.done || (w_acc && i_item.cmd == CMD_CLEAR);

    always_comb begin
        if (r_slots == '0) begin
            w_n = NSL_W'(1);
        end else if (r_slots > NSL_W'(SLOTS)) begin
            w_n = NSL_W'(SLOTS);
        end else begin
            w_n = r_slots;
        end
    end

    always_comb begin
        w_job        = '0;
        w_job.go     = w_end && !r_long;
        w_job.clear  = w_acc && (i_item.cmd == CMD_CLEAR);
        w_job.is_add = (i_item.cmd == CMD_ADD);
        w_job.sum    = r_wsum;
        w_job.n      = w_n;
        w_job.len    = r_wlen;
    end

    wfh_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job),
        .i_bytes (r_wbytes),
        .o_busy  (w_tbl_busy),
        .o_res   (w_tres)
    );

    // word assembly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= '0;
            r_wsum <= '0;
            r_long <= 1'b0;
        end else if (w_drop) begin
            r_wlen <= '0;
            r_wsum <= '0;
            r_long <= 1'b0;
        end else if (w_acc && (i_item.cmd == CMD_ADD || i_item.cmd == CMD_QUERY)
                     && (i_item.byte_in != r_sep)) begin
            if (r_wlen < LEN_W'(MAX_WORD_LEN)) begin
                r_wlen <= r_wlen + 1'b1;
                r_wsum <= r_wsum + SUM_W'(i_item.byte_in);
            end else begin
                r_long <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_item.cmd == CMD_ADD || i_item.cmd == CMD_QUERY)
            && (i_item.byte_in != r_sep) && (r_wlen < LEN_W'(MAX_WORD_LEN))) begin
            r_wbytes[r_wlen[IDX_W-1:0]] <= i_item.byte_in;
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep   <= BYTE_W'(SEP_RESET);
            r_slots <= NSL_W'(SLOTS);
        end else if (w_cfg_wr) begin
            if (paddr[2]) begin
                r_slots <= pwdata[NSL_W-1:0];
            end else begin
                r_sep <= pwdata[BYTE_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? 32'(r_slots) : 32'(r_sep);
    assign pready = 1'b1;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_long_res || w_tres.done;
        end
        if (w_long_res) begin
            r_res <= '{status: ST_LONG, count: '0, slot: '0};
        end else begin
            r_res <= w_tres.res;
        end
    end

    assign busy     = w_tbl_busy;
    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_valid_not_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a word is in the table");

    a_clear_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_CLEAR) |=> !o_valid)
        else $error("clear produced a result");

    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == ST_ABSENT || o_result.status == ST_FULL
                     || o_result.status == ST_LONG))
        |-> (o_result.count == '0 && o_result.slot == '0))
        else $error("miss result carries count or slot");

    a_new_count_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_NEW) |-> (o_result.count == CNT_W'(1)))
        else $error("new entry count is not one");

endmodule
